// File: design/mbk_pkg.sv
// mbk_pkg: shared types and codes for the markdown block kind classifier.
// No dependencies.
package mbk_pkg;

    // block kinds
    localparam logic [2:0] KIND_PARA  = 3'd0;
    localparam logic [2:0] KIND_HEAD  = 3'd1;
    localparam logic [2:0] KIND_CODE  = 3'd2;
    localparam logic [2:0] KIND_RULE  = 3'd3;
    localparam logic [2:0] KIND_IMAGE = 3'd4;
    localparam logic [2:0] KIND_MATH  = 3'd5;
    localparam logic [2:0] KIND_LIST  = 3'd6;
    localparam logic [2:0] KIND_QUOTE = 3'd7;

    // ATX heading verdict
    localparam logic [1:0] ATX_PENDING = 2'd0;
    localparam logic [1:0] ATX_YES     = 2'd1;
    localparam logic [1:0] ATX_NO      = 2'd2;

    // setext underline phases
    localparam logic [2:0] UL_LEAD  = 3'd0;
    localparam logic [2:0] UL_EQ    = 3'd1;
    localparam logic [2:0] UL_DASH  = 3'd2;
    localparam logic [2:0] UL_TRAIL = 3'd3;
    localparam logic [2:0] UL_FAIL  = 3'd4;

    // horizontal rule phases
    localparam logic [2:0] HR_LEAD  = 3'd0;
    localparam logic [2:0] HR_M1    = 3'd1;
    localparam logic [2:0] HR_M2    = 3'd2;
    localparam logic [2:0] HR_M3    = 3'd3;
    localparam logic [2:0] HR_TRAIL = 3'd4;
    localparam logic [2:0] HR_FAIL  = 3'd5;

    // rule marks
    localparam logic [1:0] MARK_NONE  = 2'd0;
    localparam logic [1:0] MARK_DASH  = 2'd1;
    localparam logic [1:0] MARK_STAR  = 2'd2;
    localparam logic [1:0] MARK_UNDER = 2'd3;

    // list item phases
    localparam logic [2:0] LI_LEAD   = 3'd0;
    localparam logic [2:0] LI_BULLET = 3'd1;
    localparam logic [2:0] LI_DIGITS = 3'd2;
    localparam logic [2:0] LI_DELIM  = 3'd3;
    localparam logic [2:0] LI_YES    = 3'd4;
    localparam logic [2:0] LI_NO     = 3'd5;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_TICK   = 8'h60;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    localparam logic [2:0] HASH_MAX   = 3'd6;
    localparam logic [1:0] INDENT_MAX = 2'd3;
    localparam logic [1:0] SEEN_MAX   = 2'd3;

    // one input beat as it moves from the input register to the scanner
    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       is_last;
    } mbk_beat_t;

    // per-buffer scan state
    typedef struct packed {
        logic [1:0] seen_count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       fence_match;
        logic [2:0] hash_run;
        logic [1:0] atx_verdict;
        logic       newline_seen;
        logic       cur_nonblank;
        logic       prev_nonblank;
        logic [2:0] ul_phase;
        logic [1:0] ul_indent;
        logic       setext_snap;
        logic [2:0] rule_phase;
        logic [1:0] rule_mark;
        logic [2:0] list_phase;
        logic [1:0] list_indent;
    } mbk_state_t;

    localparam mbk_state_t STATE_RESET = '{
        seen_count:    2'd0,
        first_byte:    8'd0,
        second_byte:   8'd0,
        fence_match:   1'b0,
        hash_run:      3'd0,
        atx_verdict:   ATX_PENDING,
        newline_seen:  1'b0,
        cur_nonblank:  1'b0,
        prev_nonblank: 1'b0,
        ul_phase:      UL_LEAD,
        ul_indent:     2'd0,
        setext_snap:   1'b0,
        rule_phase:    HR_LEAD,
        rule_mark:     MARK_NONE,
        list_phase:    LI_LEAD,
        list_indent:   2'd0
    };

endpackage

// File: design/mbk_scan.sv
// mbk_scan: per-buffer scan state, its byte update and the final classification.
// Depends on mbk_pkg.
module mbk_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  mbk_pkg::mbk_beat_t beat,
    output logic [2:0]        kind
);

    mbk_pkg::mbk_state_t st_reg;
    mbk_pkg::mbk_state_t st_next;
    mbk_pkg::mbk_state_t tk;   // state after taking this beat's byte

    logic [7:0] c;
    logic       c_ws;
    logic       c_sptab;
    logic       c_digit;
    logic [1:0] c_mark;

    function automatic logic line_nonempty(input mbk_pkg::mbk_state_t s);
        return s.ul_phase != mbk_pkg::UL_LEAD || s.ul_indent != 2'd0;
    endfunction

    function automatic logic line_verdict(input mbk_pkg::mbk_state_t s);
        logic shape;
        shape = s.ul_phase == mbk_pkg::UL_EQ || s.ul_phase == mbk_pkg::UL_DASH ||
                s.ul_phase == mbk_pkg::UL_TRAIL;
        return s.newline_seen && shape && s.prev_nonblank;
    endfunction

    assign c       = beat.char_code;
    assign c_sptab = c == mbk_pkg::CH_SPACE || c == mbk_pkg::CH_TAB;
    assign c_ws    = c_sptab || c == mbk_pkg::CH_LF || c == mbk_pkg::CH_VT ||
                     c == mbk_pkg::CH_FF || c == mbk_pkg::CH_CR;
    assign c_digit = c >= mbk_pkg::CH_ZERO && c <= mbk_pkg::CH_NINE;
    assign c_mark  = (c == mbk_pkg::CH_DASH)  ? mbk_pkg::MARK_DASH :
                     (c == mbk_pkg::CH_STAR)  ? mbk_pkg::MARK_STAR :
                     (c == mbk_pkg::CH_UNDER) ? mbk_pkg::MARK_UNDER : mbk_pkg::MARK_NONE;

    always_comb begin
        tk = st_reg;
        if (beat.has_char) begin
            // leading bytes
            case (st_reg.seen_count)
                2'd0: tk.first_byte = c;
                2'd1: tk.second_byte = c;
                2'd2: tk.fence_match = (c == mbk_pkg::CH_TICK || c == mbk_pkg::CH_TILDE) &&
                                       st_reg.first_byte == c && st_reg.second_byte == c;
                default: ;
            endcase
            if (st_reg.seen_count != mbk_pkg::SEEN_MAX) begin
                tk.seen_count = st_reg.seen_count + 2'd1;
            end

            // ATX heading
            if (st_reg.atx_verdict == mbk_pkg::ATX_PENDING) begin
                if (c == mbk_pkg::CH_HASH && st_reg.hash_run < mbk_pkg::HASH_MAX) begin
                    tk.hash_run = st_reg.hash_run + 3'd1;
                end else if (st_reg.hash_run == 3'd0) begin
                    tk.atx_verdict = mbk_pkg::ATX_NO;
                end else begin
                    tk.atx_verdict = (c == mbk_pkg::CH_SPACE || c == mbk_pkg::CH_LF) ?
                                     mbk_pkg::ATX_YES : mbk_pkg::ATX_NO;
                end
            end

            // horizontal rule
            unique case (st_reg.rule_phase) inside
                mbk_pkg::HR_LEAD: begin
                    if (c_mark != mbk_pkg::MARK_NONE) begin
                        tk.rule_mark  = c_mark;
                        tk.rule_phase = mbk_pkg::HR_M1;
                    end else if (!c_ws) begin
                        tk.rule_phase = mbk_pkg::HR_FAIL;
                    end
                end
                mbk_pkg::HR_M1, mbk_pkg::HR_M2, mbk_pkg::HR_M3: begin
                    if (c_mark != mbk_pkg::MARK_NONE && c_mark == st_reg.rule_mark &&
                        st_reg.rule_phase != mbk_pkg::HR_M3) begin
                        tk.rule_phase = st_reg.rule_phase + 3'd1;
                    end else if (c_ws && st_reg.rule_phase == mbk_pkg::HR_M3) begin
                        tk.rule_phase = mbk_pkg::HR_TRAIL;
                    end else begin
                        tk.rule_phase = mbk_pkg::HR_FAIL;
                    end
                end
                mbk_pkg::HR_TRAIL: begin
                    if (!c_ws) tk.rule_phase = mbk_pkg::HR_FAIL;
                end
                default: tk.rule_phase = mbk_pkg::HR_FAIL;
            endcase

            // list item
            unique case (st_reg.list_phase) inside
                mbk_pkg::LI_LEAD: begin
                    if (c_sptab) begin
                        if (st_reg.list_indent < mbk_pkg::INDENT_MAX) begin
                            tk.list_indent = st_reg.list_indent + 2'd1;
                        end else begin
                            tk.list_phase = mbk_pkg::LI_NO;
                        end
                    end else if (c == mbk_pkg::CH_DASH || c == mbk_pkg::CH_STAR ||
                                 c == mbk_pkg::CH_PLUS) begin
                        tk.list_phase = mbk_pkg::LI_BULLET;
                    end else if (c_digit) begin
                        tk.list_phase = mbk_pkg::LI_DIGITS;
                    end else begin
                        tk.list_phase = mbk_pkg::LI_NO;
                    end
                end
                mbk_pkg::LI_BULLET, mbk_pkg::LI_DELIM: begin
                    tk.list_phase = c_ws ? mbk_pkg::LI_YES : mbk_pkg::LI_NO;
                end
                mbk_pkg::LI_DIGITS: begin
                    if (c_digit) begin
                        tk.list_phase = mbk_pkg::LI_DIGITS;
                    end else if (c == mbk_pkg::CH_DOT || c == mbk_pkg::CH_RPAREN) begin
                        tk.list_phase = mbk_pkg::LI_DELIM;
                    end else begin
                        tk.list_phase = mbk_pkg::LI_NO;
                    end
                end
                mbk_pkg::LI_YES: ;
                default: tk.list_phase = mbk_pkg::LI_NO;
            endcase

            // setext heading, line by line
            if (c == mbk_pkg::CH_LF) begin
                if (line_nonempty(st_reg)) tk.setext_snap = line_verdict(st_reg);
                tk.prev_nonblank = st_reg.cur_nonblank;
                tk.cur_nonblank  = 1'b0;
                tk.ul_phase      = mbk_pkg::UL_LEAD;
                tk.ul_indent     = 2'd0;
                tk.newline_seen  = 1'b1;
            end else begin
                if (!c_ws) tk.cur_nonblank = 1'b1;
                unique case (st_reg.ul_phase) inside
                    mbk_pkg::UL_LEAD: begin
                        if (c_sptab) begin
                            if (st_reg.ul_indent < mbk_pkg::INDENT_MAX) begin
                                tk.ul_indent = st_reg.ul_indent + 2'd1;
                            end else begin
                                tk.ul_phase = mbk_pkg::UL_FAIL;
                            end
                        end else if (c == mbk_pkg::CH_EQUAL) begin
                            tk.ul_phase = mbk_pkg::UL_EQ;
                        end else if (c == mbk_pkg::CH_DASH) begin
                            tk.ul_phase = mbk_pkg::UL_DASH;
                        end else begin
                            tk.ul_phase = mbk_pkg::UL_FAIL;
                        end
                    end
                    mbk_pkg::UL_EQ, mbk_pkg::UL_DASH: begin
                        if ((st_reg.ul_phase == mbk_pkg::UL_EQ && c == mbk_pkg::CH_EQUAL) ||
                            (st_reg.ul_phase == mbk_pkg::UL_DASH && c == mbk_pkg::CH_DASH)) begin
                            tk.ul_phase = st_reg.ul_phase;
                        end else if (c_sptab) begin
                            tk.ul_phase = mbk_pkg::UL_TRAIL;
                        end else begin
                            tk.ul_phase = mbk_pkg::UL_FAIL;
                        end
                    end
                    mbk_pkg::UL_TRAIL: begin
                        if (!c_sptab) tk.ul_phase = mbk_pkg::UL_FAIL;
                    end
                    default: tk.ul_phase = mbk_pkg::UL_FAIL;
                endcase
            end
        end
    end

    // classification, by priority, on the state that includes this byte
    always_comb begin
        logic setext;
        setext = line_nonempty(tk) ? line_verdict(tk) : tk.setext_snap;
        if (tk.seen_count == 2'd0) begin
            kind = mbk_pkg::KIND_PARA;
        end else if (tk.atx_verdict == mbk_pkg::ATX_YES ||
                     (tk.atx_verdict == mbk_pkg::ATX_PENDING && tk.hash_run != 3'd0)) begin
            kind = mbk_pkg::KIND_HEAD;
        end else if (tk.seen_count == mbk_pkg::SEEN_MAX && tk.fence_match) begin
            kind = mbk_pkg::KIND_CODE;
        end else if (setext) begin
            kind = mbk_pkg::KIND_HEAD;
        end else if (!tk.newline_seen && (tk.rule_phase == mbk_pkg::HR_M3 ||
                                          tk.rule_phase == mbk_pkg::HR_TRAIL)) begin
            kind = mbk_pkg::KIND_RULE;
        end else if (tk.seen_count >= 2'd2 && tk.first_byte == mbk_pkg::CH_BANG &&
                     tk.second_byte == mbk_pkg::CH_LBRACK) begin
            kind = mbk_pkg::KIND_IMAGE;
        end else if (tk.first_byte == mbk_pkg::CH_DOLLAR) begin
            kind = mbk_pkg::KIND_MATH;
        end else if (tk.list_phase == mbk_pkg::LI_YES) begin
            kind = mbk_pkg::KIND_LIST;
        end else if (tk.first_byte == mbk_pkg::CH_GT &&
                     (tk.seen_count == 2'd1 || tk.second_byte == mbk_pkg::CH_SPACE)) begin
            kind = mbk_pkg::KIND_QUOTE;
        end else begin
            kind = mbk_pkg::KIND_PARA;
        end
    end

    // state returns to reset after each buffer ends
    assign st_next = beat.is_last ? mbk_pkg::STATE_RESET : tk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= mbk_pkg::STATE_RESET;
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

endmodule

// File: design/markdown_block_kind_classifier.sv
// markdown_block_kind_classifier: top level, input register, scanner and result register.
// Depends on mbk_pkg and mbk_scan.
//
// Usage
//   Input channel (s_valid/s_ready): one beat per byte of a text buffer.
//   s_has_char marks a real byte in s_char_code; s_is_last ends the buffer.
//   A beat with s_is_last and no byte closes an empty buffer. A beat with
//   neither flag is an idle beat and changes nothing.
//   Result channel (m_valid/m_ready): one beat per buffer, m_block_kind is
//   0 paragraph, 1 heading, 2 code, 3 rule, 4 image, 5 math, 6 list, 7 quote.
// Timing
//   A beat lands in the input register; the scanner updates its flags and
//   classifies combinationally, and a final beat loads the result register.
//   One beat per cycle sustained, unless a final beat waits on a full result.
// Reset
//   aresetn low clears both valid flags and all scan state; a new buffer
//   starts at the first beat after reset.
// Stall
//   While a result waits on m_ready, non-final beats keep flowing through
//   the scanner; a final beat waits in the input register, with s_ready
//   low, until the result register frees.
module markdown_block_kind_classifier (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_has_char,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_block_kind
);

    // input register
    logic               in_valid_reg;
    mbk_pkg::mbk_beat_t in_beat_reg;

    // result register
    logic       out_valid_reg;
    logic [2:0] out_kind_reg;

    logic       out_free;
    logic       advance;
    logic [2:0] scan_kind;

    // result slot is free if empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;
    // a held beat moves through the scanner unless it needs a busy result slot
    assign advance  = in_valid_reg && (!in_beat_reg.is_last || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_beat_reg.char_code <= s_char_code;
            in_beat_reg.has_char  <= s_has_char;
            in_beat_reg.is_last   <= s_is_last;
        end
    end

    mbk_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .beat    (in_beat_reg),
        .kind    (scan_kind)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_beat_reg.is_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_beat_reg.is_last) begin
            out_kind_reg <= scan_kind;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_block_kind = out_kind_reg;

    // a final beat that steps the scanner always leaves a result behind
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_beat_reg.is_last |=> out_valid_reg)
        else $error("final beat did not load the result register");

    // a final beat never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !(advance && in_beat_reg.is_last))
        else $error("pending result overwritten");

    // non-final beats never stall on the result side
    a_nonlast_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !in_beat_reg.is_last |-> s_ready)
        else $error("non-final beat stalled");

    // a held final beat blocks intake only while the result slot is busy
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && in_beat_reg.is_last && out_valid_reg && !m_ready)
        else $error("input stalled without cause");

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for markdown_block_kind_classifier.
// Drives text buffers byte by byte, predicts the block kind of each buffer
// and checks every result beat. Depends on mbk_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_BEATS  = 1350;
    localparam int DIRECTED_ROWS = 23;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 10;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    // One input beat plus, where it is obvious, the kind it must produce.
    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
        logic       typed;
        logic [2:0] kind;
    } beat_row_t;

    // Directed rows: one buffer per special case. Expected kinds are typed in
    // where they are plain; the setext heading goes through the predictor,
    // and the idle beat yields no result.
    localparam beat_row_t DIRECTED_TBL [0:DIRECTED_ROWS-1] = '{
        '{8'h00,              1'b0, 1'b1, 1'b1, mbk_pkg::KIND_PARA},   // empty buffer
        '{mbk_pkg::CH_HASH,   1'b1, 1'b1, 1'b1, mbk_pkg::KIND_HEAD},   // lone '#' at the end
        '{mbk_pkg::CH_TICK,   1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA},
        '{mbk_pkg::CH_TICK,   1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA},
        '{mbk_pkg::CH_TICK,   1'b1, 1'b1, 1'b1, mbk_pkg::KIND_CODE},   // backtick fence
        '{mbk_pkg::CH_TILDE,  1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA},
        '{mbk_pkg::CH_TILDE,  1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA},
        '{mbk_pkg::CH_TILDE,  1'b1, 1'b1, 1'b1, mbk_pkg::KIND_CODE},   // tilde fence
        '{mbk_pkg::CH_DOLLAR, 1'b1, 1'b1, 1'b1, mbk_pkg::KIND_MATH},
        '{mbk_pkg::CH_GT,     1'b1, 1'b1, 1'b1, mbk_pkg::KIND_QUOTE},  // exactly ">"
        '{mbk_pkg::CH_DASH,   1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA},
        '{mbk_pkg::CH_DASH,   1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA},
        '{mbk_pkg::CH_DASH,   1'b1, 1'b1, 1'b1, mbk_pkg::KIND_RULE},
        '{mbk_pkg::CH_BANG,   1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA},
        '{mbk_pkg::CH_LBRACK, 1'b1, 1'b1, 1'b1, mbk_pkg::KIND_IMAGE},
        '{mbk_pkg::CH_DASH,   1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA},
        '{mbk_pkg::CH_SPACE,  1'b1, 1'b1, 1'b1, mbk_pkg::KIND_LIST},
        '{8'hA5,              1'b0, 1'b0, 1'b0, mbk_pkg::KIND_PARA},   // idle beat, no result
        '{8'hFF,              1'b1, 1'b1, 1'b1, mbk_pkg::KIND_PARA},   // top byte value
        '{CH_LOWER_A,         1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA},
        '{mbk_pkg::CH_LF,     1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA},
        '{mbk_pkg::CH_EQUAL,  1'b1, 1'b1, 1'b0, mbk_pkg::KIND_PARA},   // setext "a\n="
        '{8'h00,              1'b1, 1'b1, 1'b1, mbk_pkg::KIND_PARA}    // bottom byte value
    };

    logic       aclk;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_code  = 8'h00;
    logic       s_has_char   = 1'b0;
    logic       s_is_last    = 1'b0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [2:0] m_block_kind;

    beat_row_t           stim_q[$];     // every beat to send, directed first
    beat_row_t           cur_row;       // beat currently on the input ports
    logic [2:0]          kind_q[$];     // block kinds still owed by the block
    mbk_pkg::mbk_state_t scan_st;       // predictor's copy of the per-buffer state
    int                  beats_taken = 0;
    int                  errors      = 0;
    int                  cycles      = 0;

    markdown_block_kind_classifier i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .s_has_char   (s_has_char),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_block_kind (m_block_kind)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Block kind predictor
    // ---------------------------------------------------------------------

    function automatic logic is_blank(logic [7:0] c);
        return c == mbk_pkg::CH_SPACE || c == mbk_pkg::CH_TAB || c == mbk_pkg::CH_LF ||
               c == mbk_pkg::CH_VT || c == mbk_pkg::CH_FF || c == mbk_pkg::CH_CR;
    endfunction

    function automatic logic is_sp_tab(logic [7:0] c);
        return c == mbk_pkg::CH_SPACE || c == mbk_pkg::CH_TAB;
    endfunction

    // current line has had at least one byte that moved the underline scan
    function automatic logic line_started();
        return scan_st.ul_phase != mbk_pkg::UL_LEAD || scan_st.ul_indent != 2'd0;
    endfunction

    function automatic logic underline_ok();
        logic shape;
        shape = scan_st.ul_phase == mbk_pkg::UL_EQ || scan_st.ul_phase == mbk_pkg::UL_DASH ||
                scan_st.ul_phase == mbk_pkg::UL_TRAIL;
        return scan_st.newline_seen && shape && scan_st.prev_nonblank;
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic [1:0] mark;
        // first three bytes: image, math, quote and fence tests
        if (scan_st.seen_count == 2'd0) begin
            scan_st.first_byte = c;
        end else if (scan_st.seen_count == 2'd1) begin
            scan_st.second_byte = c;
        end else if (scan_st.seen_count == 2'd2) begin
            scan_st.fence_match = (c == mbk_pkg::CH_TICK || c == mbk_pkg::CH_TILDE) &&
                                  scan_st.first_byte == c && scan_st.second_byte == c;
        end
        if (scan_st.seen_count < mbk_pkg::SEEN_MAX)
            scan_st.seen_count = scan_st.seen_count + 2'd1;

        // ATX heading: run of '#' then space, LF or end
        if (scan_st.atx_verdict == mbk_pkg::ATX_PENDING) begin
            if (c == mbk_pkg::CH_HASH && scan_st.hash_run < mbk_pkg::HASH_MAX) begin
                scan_st.hash_run = scan_st.hash_run + 3'd1;
            end else if (scan_st.hash_run == 3'd0) begin
                scan_st.atx_verdict = mbk_pkg::ATX_NO;
            end else begin
                scan_st.atx_verdict = (c == mbk_pkg::CH_SPACE || c == mbk_pkg::CH_LF) ?
                                      mbk_pkg::ATX_YES : mbk_pkg::ATX_NO;
            end
        end

        // horizontal rule: exactly three equal marks between blanks
        mark = (c == mbk_pkg::CH_DASH)  ? mbk_pkg::MARK_DASH :
               (c == mbk_pkg::CH_STAR)  ? mbk_pkg::MARK_STAR :
               (c == mbk_pkg::CH_UNDER) ? mbk_pkg::MARK_UNDER : mbk_pkg::MARK_NONE;
        case (scan_st.rule_phase)
            mbk_pkg::HR_LEAD: begin
                if (mark != mbk_pkg::MARK_NONE) begin
                    scan_st.rule_mark  = mark;
                    scan_st.rule_phase = mbk_pkg::HR_M1;
                end else if (!is_blank(c)) begin
                    scan_st.rule_phase = mbk_pkg::HR_FAIL;
                end
            end
            mbk_pkg::HR_M1, mbk_pkg::HR_M2, mbk_pkg::HR_M3: begin
                if (mark != mbk_pkg::MARK_NONE && mark == scan_st.rule_mark &&
                    scan_st.rule_phase != mbk_pkg::HR_M3) begin
                    scan_st.rule_phase = scan_st.rule_phase + 3'd1;
                end else if (is_blank(c)) begin
                    scan_st.rule_phase = (scan_st.rule_phase == mbk_pkg::HR_M3) ?
                                         mbk_pkg::HR_TRAIL : mbk_pkg::HR_FAIL;
                end else begin
                    scan_st.rule_phase = mbk_pkg::HR_FAIL;
                end
            end
            mbk_pkg::HR_TRAIL: begin
                if (!is_blank(c)) scan_st.rule_phase = mbk_pkg::HR_FAIL;
            end
            default: scan_st.rule_phase = mbk_pkg::HR_FAIL;
        endcase

        // list item marker
        case (scan_st.list_phase)
            mbk_pkg::LI_LEAD: begin
                if (is_sp_tab(c)) begin
                    if (scan_st.list_indent < mbk_pkg::INDENT_MAX)
                        scan_st.list_indent = scan_st.list_indent + 2'd1;
                    else
                        scan_st.list_phase = mbk_pkg::LI_NO;
                end else if (c == mbk_pkg::CH_DASH || c == mbk_pkg::CH_STAR ||
                             c == mbk_pkg::CH_PLUS) begin
                    scan_st.list_phase = mbk_pkg::LI_BULLET;
                end else if (c >= mbk_pkg::CH_ZERO && c <= mbk_pkg::CH_NINE) begin
                    scan_st.list_phase = mbk_pkg::LI_DIGITS;
                end else begin
                    scan_st.list_phase = mbk_pkg::LI_NO;
                end
            end
            mbk_pkg::LI_BULLET, mbk_pkg::LI_DELIM: begin
                scan_st.list_phase = is_blank(c) ? mbk_pkg::LI_YES : mbk_pkg::LI_NO;
            end
            mbk_pkg::LI_DIGITS: begin
                if (c >= mbk_pkg::CH_ZERO && c <= mbk_pkg::CH_NINE)
                    scan_st.list_phase = mbk_pkg::LI_DIGITS;
                else if (c == mbk_pkg::CH_DOT || c == mbk_pkg::CH_RPAREN)
                    scan_st.list_phase = mbk_pkg::LI_DELIM;
                else
                    scan_st.list_phase = mbk_pkg::LI_NO;
            end
            mbk_pkg::LI_YES: ;
            default: scan_st.list_phase = mbk_pkg::LI_NO;
        endcase

        // setext underline, tracked per line; a LF closes the line
        if (c == mbk_pkg::CH_LF) begin
            if (line_started()) scan_st.setext_snap = underline_ok();
            scan_st.prev_nonblank = scan_st.cur_nonblank;
            scan_st.cur_nonblank  = 1'b0;
            scan_st.ul_phase      = mbk_pkg::UL_LEAD;
            scan_st.ul_indent     = 2'd0;
            scan_st.newline_seen  = 1'b1;
            return;
        end
        if (!is_blank(c)) scan_st.cur_nonblank = 1'b1;
        case (scan_st.ul_phase)
            mbk_pkg::UL_LEAD: begin
                if (is_sp_tab(c)) begin
                    if (scan_st.ul_indent < mbk_pkg::INDENT_MAX)
                        scan_st.ul_indent = scan_st.ul_indent + 2'd1;
                    else
                        scan_st.ul_phase = mbk_pkg::UL_FAIL;
                end else if (c == mbk_pkg::CH_EQUAL) begin
                    scan_st.ul_phase = mbk_pkg::UL_EQ;
                end else if (c == mbk_pkg::CH_DASH) begin
                    scan_st.ul_phase = mbk_pkg::UL_DASH;
                end else begin
                    scan_st.ul_phase = mbk_pkg::UL_FAIL;
                end
            end
            mbk_pkg::UL_EQ, mbk_pkg::UL_DASH: begin
                if ((scan_st.ul_phase == mbk_pkg::UL_EQ && c == mbk_pkg::CH_EQUAL) ||
                    (scan_st.ul_phase == mbk_pkg::UL_DASH && c == mbk_pkg::CH_DASH)) begin
                    // run goes on
                end else if (is_sp_tab(c)) begin
                    scan_st.ul_phase = mbk_pkg::UL_TRAIL;
                end else begin
                    scan_st.ul_phase = mbk_pkg::UL_FAIL;
                end
            end
            mbk_pkg::UL_TRAIL: begin
                if (!is_sp_tab(c)) scan_st.ul_phase = mbk_pkg::UL_FAIL;
            end
            default: scan_st.ul_phase = mbk_pkg::UL_FAIL;
        endcase
    endfunction

    // kind of the buffer scanned so far, highest priority test first
    function automatic logic [2:0] block_kind_of();
        logic setext;
        if (scan_st.seen_count == 2'd0) return mbk_pkg::KIND_PARA;
        if (scan_st.atx_verdict == mbk_pkg::ATX_YES ||
            (scan_st.atx_verdict == mbk_pkg::ATX_PENDING && scan_st.hash_run != 3'd0))
            return mbk_pkg::KIND_HEAD;
        if (scan_st.seen_count == mbk_pkg::SEEN_MAX && scan_st.fence_match)
            return mbk_pkg::KIND_CODE;
        setext = line_started() ? underline_ok() : scan_st.setext_snap;
        if (setext) return mbk_pkg::KIND_HEAD;
        if (!scan_st.newline_seen &&
            (scan_st.rule_phase == mbk_pkg::HR_M3 || scan_st.rule_phase == mbk_pkg::HR_TRAIL))
            return mbk_pkg::KIND_RULE;
        if (scan_st.seen_count >= 2'd2 && scan_st.first_byte == mbk_pkg::CH_BANG &&
            scan_st.second_byte == mbk_pkg::CH_LBRACK)
            return mbk_pkg::KIND_IMAGE;
        if (scan_st.first_byte == mbk_pkg::CH_DOLLAR) return mbk_pkg::KIND_MATH;
        if (scan_st.list_phase == mbk_pkg::LI_YES) return mbk_pkg::KIND_LIST;
        if (scan_st.first_byte == mbk_pkg::CH_GT &&
            (scan_st.seen_count == 2'd1 || scan_st.second_byte == mbk_pkg::CH_SPACE))
            return mbk_pkg::KIND_QUOTE;
        return mbk_pkg::KIND_PARA;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 5))
            0:       return mbk_pkg::CH_SPACE;
            1:       return mbk_pkg::CH_TAB;
            2:       return mbk_pkg::CH_LF;
            3:       return mbk_pkg::CH_VT;
            4:       return mbk_pkg::CH_FF;
            default: return mbk_pkg::CH_CR;
        endcase
    endfunction

    // byte drawn mostly from the characters the tests care about
    function automatic logic [7:0] md_byte();
        case ($urandom_range(0, 23))
            0:       return mbk_pkg::CH_HASH;
            1:       return mbk_pkg::CH_SPACE;
            2:       return mbk_pkg::CH_TAB;
            3:       return mbk_pkg::CH_LF;
            4:       return mbk_pkg::CH_TICK;
            5:       return mbk_pkg::CH_TILDE;
            6:       return mbk_pkg::CH_EQUAL;
            7:       return mbk_pkg::CH_DASH;
            8:       return mbk_pkg::CH_STAR;
            9:       return mbk_pkg::CH_UNDER;
            10:      return mbk_pkg::CH_BANG;
            11:      return mbk_pkg::CH_LBRACK;
            12:      return mbk_pkg::CH_DOLLAR;
            13:      return mbk_pkg::CH_PLUS;
            14:      return mbk_pkg::CH_DOT;
            15:      return mbk_pkg::CH_RPAREN;
            16:      return mbk_pkg::CH_GT;
            17:      return 8'($urandom_range(mbk_pkg::CH_ZERO, mbk_pkg::CH_NINE));
            18:      return blank_byte();
            19:      return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Scoreboard: predict on every accepted input beat, check every result
    // beat against the oldest owed kind. Both sides are sampled at the
    // rising edge; the ports only move at the falling edge.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        logic [2:0] want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                beats_taken = beats_taken + 1;
                if (cur_row.has) scan_byte(cur_row.ch);
                if (cur_row.last) begin
                    kind_q.push_back(cur_row.typed ? cur_row.kind : block_kind_of());
                    scan_st = mbk_pkg::STATE_RESET;
                end
            end
            if (m_valid && m_ready) begin
                if (kind_q.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result beat with none owed, kind %0d",
                                 $realtime, m_block_kind);
                    errors = errors + 1;
                end else begin
                    want = kind_q.pop_front();
                    if (m_block_kind !== want) begin
                        if (errors < 10)
                            $display("%0t: block_kind expected %0d got %0d",
                                     $realtime, want, m_block_kind);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: m_ready follows patterns of its own; once, a long hold-off
    // so the result register stays full while bytes keep arriving and the
    // block has to drop s_ready on a final beat.
    // ---------------------------------------------------------------------
    initial begin : receiver
        int  mode;
        int  seg;
        bit  held;
        held = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (!held && beats_taken >= 200) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                held = 1'b1;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 80);
            repeat (seg) begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 4) == 0);
                    default: m_ready <= (cycles % 3 != 0);
                endcase
                @(negedge aclk);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender: builds the stimulus, then offers it in bursts with random gaps.
    // ---------------------------------------------------------------------
    initial begin : sender
        logic [7:0] txt[$];
        logic [7:0] mk;
        beat_row_t  row;
        int         n_random;
        int         burst;
        int         gap;
        int         pause_at;
        bit         paused;

        scan_st = mbk_pkg::STATE_RESET;
        cur_row = '0;

        for (int i = 0; i < DIRECTED_ROWS; i++) stim_q.push_back(DIRECTED_TBL[i]);

        // Random buffers: mostly shaped like one of the block kinds, with
        // random content, slips in the shape and a random tail.
        n_random = 0;
        while (n_random < RANDOM_BEATS) begin
            txt.delete();
            case ($urandom_range(0, 9))
                0: begin    // ATX heading, 1 to 8 hashes
                    repeat ($urandom_range(1, 8)) txt.push_back(mbk_pkg::CH_HASH);
                    case ($urandom_range(0, 3))
                        0: txt.push_back(mbk_pkg::CH_SPACE);
                        1: txt.push_back(mbk_pkg::CH_LF);
                        2: txt.push_back(md_byte());
                        default: ;
                    endcase
                end
                1: begin    // code fence
                    mk = $urandom_range(0, 1) ? mbk_pkg::CH_TICK : mbk_pkg::CH_TILDE;
                    txt.push_back(mk);
                    txt.push_back(mk);
                    txt.push_back(($urandom_range(0, 4) == 0) ? md_byte() : mk);
                end
                2: begin    // setext heading: text line, then underline
                    if ($urandom_range(0, 3) != 0)
                        repeat ($urandom_range(1, 4)) txt.push_back(md_byte());
                    else if ($urandom_range(0, 1))
                        txt.push_back(mbk_pkg::CH_SPACE);
                    txt.push_back(mbk_pkg::CH_LF);
                    repeat ($urandom_range(0, 4))
                        txt.push_back($urandom_range(0, 1) ? mbk_pkg::CH_SPACE : mbk_pkg::CH_TAB);
                    mk = $urandom_range(0, 1) ? mbk_pkg::CH_EQUAL : mbk_pkg::CH_DASH;
                    repeat ($urandom_range(1, 4)) txt.push_back(mk);
                    repeat ($urandom_range(0, 2))
                        txt.push_back($urandom_range(0, 1) ? mbk_pkg::CH_SPACE : mbk_pkg::CH_TAB);
                    if ($urandom_range(0, 5) == 0) txt.push_back(md_byte());
                    repeat ($urandom_range(0, 2)) txt.push_back(mbk_pkg::CH_LF);
                end
                3: begin    // horizontal rule
                    repeat ($urandom_range(0, 2)) txt.push_back(blank_byte());
                    case ($urandom_range(0, 2))
                        0:       mk = mbk_pkg::CH_DASH;
                        1:       mk = mbk_pkg::CH_STAR;
                        default: mk = mbk_pkg::CH_UNDER;
                    endcase
                    repeat ($urandom_range(2, 4))
                        txt.push_back(($urandom_range(0, 7) == 0) ? mbk_pkg::CH_STAR : mk);
                    repeat ($urandom_range(0, 2)) txt.push_back(blank_byte());
                end
                4: begin    // image
                    txt.push_back(mbk_pkg::CH_BANG);
                    txt.push_back(($urandom_range(0, 3) != 0) ? mbk_pkg::CH_LBRACK : md_byte());
                end
                5: txt.push_back(mbk_pkg::CH_DOLLAR);
                6: begin    // list item, bullet or ordered
                    repeat ($urandom_range(0, 4))
                        txt.push_back($urandom_range(0, 1) ? mbk_pkg::CH_SPACE : mbk_pkg::CH_TAB);
                    if ($urandom_range(0, 1)) begin
                        case ($urandom_range(0, 2))
                            0:       txt.push_back(mbk_pkg::CH_DASH);
                            1:       txt.push_back(mbk_pkg::CH_STAR);
                            default: txt.push_back(mbk_pkg::CH_PLUS);
                        endcase
                    end else begin
                        repeat ($urandom_range(1, 3))
                            txt.push_back(8'($urandom_range(mbk_pkg::CH_ZERO,
                                                            mbk_pkg::CH_NINE)));
                        case ($urandom_range(0, 2))
                            0:       txt.push_back(mbk_pkg::CH_DOT);
                            1:       txt.push_back(mbk_pkg::CH_RPAREN);
                            default: txt.push_back(md_byte());
                        endcase
                    end
                    txt.push_back(($urandom_range(0, 3) != 0) ? blank_byte() : md_byte());
                end
                7: begin    // blockquote
                    txt.push_back(mbk_pkg::CH_GT);
                    case ($urandom_range(0, 2))
                        0: txt.push_back(mbk_pkg::CH_SPACE);
                        1: txt.push_back(md_byte());
                        default: ;
                    endcase
                end
                8: repeat ($urandom_range(0, 12)) txt.push_back(md_byte());
                default: repeat ($urandom_range(0, 8)) txt.push_back(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(0, 5)) txt.push_back(md_byte());

            // emit bytes, with an occasional idle beat in between
            for (int k = 0; k < txt.size(); k++) begin
                if ($urandom_range(0, 11) == 0) begin
                    row = '{8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, mbk_pkg::KIND_PARA};
                    stim_q.push_back(row);
                    n_random++;
                end
                row = '{txt[k], 1'b1, 1'b0, 1'b0, mbk_pkg::KIND_PARA};
                stim_q.push_back(row);
                n_random++;
            end
            // end marker: on the last byte, or a separate byte-less beat
            if (txt.size() == 0 || $urandom_range(0, 4) == 0) begin
                row = '{8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, mbk_pkg::KIND_PARA};
                stim_q.push_back(row);
                n_random++;
            end else begin
                stim_q[stim_q.size() - 1].last = 1'b1;
            end
        end

        pause_at = stim_q.size() / 2;
        paused   = 1'b0;
        burst    = 0;

        @(negedge aclk);
        while (!aresetn) @(negedge aclk);

        for (int i = 0; i < stim_q.size(); i++) begin
            if (!paused && i >= pause_at && stim_q[i-1].last) begin
                // let the block drain completely once, then resume
                s_valid <= 1'b0;
                do @(negedge aclk); while (kind_q.size() != 0);
                repeat (4) @(negedge aclk);
                paused = 1'b1;
                burst  = $urandom_range(1, 30);
            end else if (burst == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                // now and then a long stretch with no gaps at all
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 30);
            end
            burst = burst - 1;
            cur_row = stim_q[i];
            s_valid     <= 1'b1;
            s_char_code <= stim_q[i].ch;
            s_has_char  <= stim_q[i].has;
            s_is_last   <= stim_q[i].last;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            @(negedge aclk);
        end
        s_valid <= 1'b0;

        // drain: every owed kind, then a wait for stray beats
        while (kind_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0 && kind_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
